>>> hdl/grid_flood_fill_reachability_assert.svh
// Assertion macros shared by the checker of the flood fill block.
`ifndef GRID_FLOOD_FILL_REACHABILITY_ASSERT_SVH
`define GRID_FLOOD_FILL_REACHABILITY_ASSERT_SVH
// An implication that must hold at every clock edge out of reset.
`define GFF_ASSERT_IMPL(label, clk, rst_n, cond, expect_q, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_q)) \
		else $error(msg);
// An implication checked in the cycle after its trigger.
`define GFF_ASSERT_NEXT(label, clk, rst_n, cond, expect_q, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_q)) \
		else $error(msg);
`endif

>>> hdl/gff_pkg.sv
// Package of shared types and constants for the flood fill block.
`timescale 1ns / 1ps
package gff_pkg;
	localparam int MaxCols   = 64;
	localparam int MaxRows   = 64;
	localparam int EventBits = 16;
	localparam int CfgBits   = 7;
	localparam int CfgIdxBits = 2;
	localparam int AnsBits   = 17;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FLOOD = 2'd1,
		OP_OPEN  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_TCOL   = 2'd2,
		CFG_TROW   = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LOAD,
		ST_FSEED,
		ST_POP,
		ST_POPW,
		ST_NREQ,
		ST_NWAIT,
		ST_NCHK,
		ST_OREQ,
		ST_OWAIT,
		ST_OLREQ,
		ST_OLWAIT,
		ST_OLCHK,
		ST_OMARK,
		ST_TREQ,
		ST_TWAIT,
		ST_OUT
	} state_t;
endpackage

>>> hdl/gff_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module gff_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> hdl/grid_flood_fill_reachability.sv
// Top level of the grid flood fill reachability block.
`timescale 1ns / 1ps
// One word in gives one word out. The wall map, the reached map and the
// breadth-first work queue each sit in a single-port RAM with a registered
// read, and a sequencer walks them one access at a time. After reset the block
// runs a clearing pass over every cell of the wall and reached maps before it
// takes its first word. A flood first clears the reached map, cell by cell, and
// then, for each reached cell, pops the queue and, for each of four neighbours,
// reads the wall and reached maps with a possible write back and push; a
// neighbour outside the grid is skipped without a read. An open reads the
// addressed cell, checks its four neighbours for a reached link and spreads the
// fill in the same way to any cells it newly reaches. The result word waits in
// an output register until taken; the next word is taken only after that.
module grid_flood_fill_reachability #(
	parameter int MAX_COLS   = gff_pkg::MaxCols,
	parameter int MAX_ROWS   = gff_pkg::MaxRows,
	parameter int EVENT_BITS = gff_pkg::EventBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [5:0]  col,
	input  logic [5:0]  row,
	input  logic        is_wall,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        target_reached,
	output logic signed [16:0] first_event,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam int CB    = $clog2(MAX_COLS);
	localparam int RB    = $clog2(MAX_ROWS);
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AB    = $clog2(CELLS);
	localparam int WB    = CB + 1;
	localparam int HB    = RB + 1;
	localparam logic [EVENT_BITS-1:0] EV_MAX = '1;

	// Configuration registers.
	logic [6:0] gw_q, gh_q;
	logic [5:0] tc_q, tr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'd64;
			gh_q <= 7'd64;
			tc_q <= '0;
			tr_q <= '0;
		end else if (cfg_we) begin
			unique case (gff_pkg::cfg_idx_t'(cfg_index))
				gff_pkg::CFG_WIDTH:  gw_q <= cfg_data;
				gff_pkg::CFG_HEIGHT: gh_q <= cfg_data;
				gff_pkg::CFG_TCOL:   tc_q <= cfg_data[5:0];
				gff_pkg::CFG_TROW:   tr_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Effective grid size, clamped to 1..MAX.
	logic [WB-1:0] eff_w;
	logic [HB-1:0] eff_h;
	always_comb begin
		if (gw_q == 7'd0) eff_w = WB'(1);
		else if (32'(gw_q) > MAX_COLS) eff_w = WB'(MAX_COLS);
		else eff_w = WB'(gw_q);
		if (gh_q == 7'd0) eff_h = HB'(1);
		else if (32'(gh_q) > MAX_ROWS) eff_h = HB'(MAX_ROWS);
		else eff_h = HB'(gh_q);
	end

	// Memories.
	logic          wall_we, wall_wd, wall_rd;
	logic          rch_we, rch_wd, rch_rd;
	logic          q_we;
	logic [AB-1:0] wall_a, rch_a, q_a, q_wd, q_rd;

	gff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
		.clk(clk), .we(wall_we), .addr(wall_a), .wdata(wall_wd), .rdata(wall_rd));
	gff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_reach (
		.clk(clk), .we(rch_we), .addr(rch_a), .wdata(rch_wd), .rdata(rch_rd));
	gff_ram #(.WIDTH(AB), .DEPTH(CELLS)) u_queue (
		.clk(clk), .we(q_we), .addr(q_a), .wdata(q_wd), .rdata(q_rd));

	// Sequencer state.
	gff_pkg::state_t st_q, st_d;
	logic [AB:0]     clr_q, clr_d;
	logic            boot_q, boot_d;
	logic [1:0]      op_q, op_d;
	logic [5:0]      c_q, c_d, r_q, r_d;
	logic            w_q, w_d;
	logic [AB-1:0]   head_q, head_d;
	logic [AB:0]     cnt_q, cnt_d;
	logic [CB-1:0]   cc_q, cc_d;
	logic [RB-1:0]   cr_q, cr_d;
	logic [1:0]      dir_q, dir_d;
	logic            link_q, link_d;
	logic [EVENT_BITS-1:0] ev_q, ev_d;
	logic signed [16:0] ans_q, ans_d;
	logic            tr_res_q, tr_res_d;

	// Neighbour of the current cell in the current direction.
	logic [CB:0] nc;
	logic [RB:0] nr;
	logic        n_in;
	always_comb begin
		nc = {1'b0, cc_q};
		nr = {1'b0, cr_q};
		case (dir_q)
			2'd0: nc = {1'b0, cc_q} + 1'b1;
			2'd1: nr = {1'b0, cr_q} + 1'b1;
			2'd2: nc = {1'b0, cc_q} - 1'b1;
			default: nr = {1'b0, cr_q} - 1'b1;
		endcase
		n_in = !nc[CB] && !nr[RB] && ((CB+1)'(nc) < (CB+1)'(eff_w))
			&& ((RB+1)'(nr) < (RB+1)'(eff_h));
	end
	logic [AB-1:0] n_addr;
	assign n_addr = {nr[RB-1:0], nc[CB-1:0]};

	// Addressed cell of an open item.
	logic          o_in;
	logic [AB-1:0] o_addr;
	assign o_in = (32'(c_q) < 32'(eff_w)) && (32'(r_q) < 32'(eff_h));
	assign o_addr = {RB'(r_q), CB'(c_q)};
	logic          t_in;
	assign t_in = (32'(tc_q) < 32'(eff_w)) && (32'(tr_q) < 32'(eff_h));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gff_pkg::ST_CLEAR;
			clr_q <= '0;
			boot_q <= 1'b1;
			head_q <= '0;
			cnt_q <= '0;
			ev_q <= '0;
			ans_q <= -17'sd1;
			tr_res_q <= 1'b0;
		end else begin
			st_q <= st_d;
			clr_q <= clr_d;
			boot_q <= boot_d;
			head_q <= head_d;
			cnt_q <= cnt_d;
			ev_q <= ev_d;
			ans_q <= ans_d;
			tr_res_q <= tr_res_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d; c_q <= c_d; r_q <= r_d; w_q <= w_d;
		cc_q <= cc_d; cr_q <= cr_d; dir_q <= dir_d; link_q <= link_d;
	end

	always_comb begin
		st_d = st_q; clr_d = clr_q; boot_d = boot_q;
		op_d = op_q; c_d = c_q; r_d = r_q; w_d = w_q;
		head_d = head_q; cnt_d = cnt_q; cc_d = cc_q; cr_d = cr_q;
		dir_d = dir_q; link_d = link_q; ev_d = ev_q; ans_d = ans_q;
		tr_res_d = tr_res_q;
		wall_we = 1'b0; wall_wd = 1'b0; wall_a = n_addr;
		rch_we = 1'b0;  rch_wd = 1'b0;  rch_a = n_addr;
		q_we = 1'b0; q_wd = n_addr; q_a = AB'(head_q + AB'(cnt_q));
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (st_q)
			gff_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					op_d = operation; c_d = col; r_d = row; w_d = is_wall;
					unique case (gff_pkg::op_t'(operation))
						gff_pkg::OP_LOAD:  st_d = gff_pkg::ST_LOAD;
						gff_pkg::OP_FLOOD: begin
							st_d = gff_pkg::ST_CLEAR;
							clr_d = '0;
						end
						gff_pkg::OP_OPEN: begin
							if (ev_q != EV_MAX) ev_d = ev_q + 1'b1;
							st_d = gff_pkg::ST_OREQ;
						end
						default: st_d = gff_pkg::ST_TREQ;
					endcase
				end
			end
			gff_pkg::ST_CLEAR: begin
				rch_a = AB'(clr_q); rch_we = 1'b1; rch_wd = 1'b0;
				wall_a = AB'(clr_q); wall_we = boot_q; wall_wd = 1'b0;
				clr_d = clr_q + 1'b1;
				if (clr_q == (AB+1)'(CELLS - 1)) begin
					if (boot_q) begin
						boot_d = 1'b0;
						st_d = gff_pkg::ST_IDLE;
					end else begin
						st_d = gff_pkg::ST_FSEED;
					end
				end
			end
			gff_pkg::ST_LOAD: begin
				wall_a = {RB'(r_q), CB'(c_q)};
				wall_we = (32'(c_q) < MAX_COLS) && (32'(r_q) < MAX_ROWS);
				wall_wd = w_q;
				st_d = gff_pkg::ST_TREQ;
			end
			gff_pkg::ST_FSEED: begin
				ev_d = '0; ans_d = -17'sd1;
				rch_a = '0; rch_we = 1'b1; rch_wd = 1'b1;
				q_a = '0; q_we = 1'b1; q_wd = '0;
				head_d = '0; cnt_d = (AB+1)'(1);
				st_d = gff_pkg::ST_POP;
			end
			gff_pkg::ST_POP: begin
				if (cnt_q == '0) begin
					st_d = gff_pkg::ST_TREQ;
				end else begin
					q_a = head_q;
					head_d = head_q + 1'b1;
					cnt_d = cnt_q - 1'b1;
					st_d = gff_pkg::ST_POPW;
				end
			end
			gff_pkg::ST_POPW: begin
				cc_d = q_rd[CB-1:0];
				cr_d = q_rd[AB-1:CB];
				dir_d = 2'd0;
				st_d = gff_pkg::ST_NREQ;
			end
			gff_pkg::ST_NREQ: begin
				if (n_in) begin
					st_d = gff_pkg::ST_NWAIT;
				end else if (dir_q == 2'd3) begin
					st_d = gff_pkg::ST_POP;
				end else begin
					dir_d = dir_q + 1'b1;
				end
			end
			gff_pkg::ST_NWAIT: st_d = gff_pkg::ST_NCHK;
			gff_pkg::ST_NCHK: begin
				if (!wall_rd && !rch_rd) begin
					rch_we = 1'b1; rch_wd = 1'b1;
					if (32'(cnt_q) < CELLS) begin
						q_we = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
				end
				if (dir_q == 2'd3) begin
					st_d = gff_pkg::ST_POP;
				end else begin
					dir_d = dir_q + 1'b1;
					st_d = gff_pkg::ST_NREQ;
				end
			end
			gff_pkg::ST_OREQ: begin
				wall_a = o_addr; rch_a = o_addr;
				if (ans_q != 17'sd0 && o_in) begin
					st_d = gff_pkg::ST_OWAIT;
				end else begin
					// An open that clears no wall never sets the first event.
					op_d = gff_pkg::OP_NONE;
					st_d = gff_pkg::ST_TREQ;
				end
			end
			gff_pkg::ST_OWAIT: begin
				wall_a = o_addr;
				if (wall_rd) begin
					wall_we = 1'b1; wall_wd = 1'b0;
					cc_d = CB'(c_q); cr_d = RB'(r_q);
					dir_d = 2'd0; link_d = 1'b0;
					w_d = rch_rd;
					st_d = gff_pkg::ST_OLREQ;
				end else begin
					op_d = gff_pkg::OP_NONE;
					st_d = gff_pkg::ST_TREQ;
				end
			end
			gff_pkg::ST_OLREQ: begin
				if (n_in) begin
					st_d = gff_pkg::ST_OLWAIT;
				end else if (dir_q == 2'd3) begin
					st_d = gff_pkg::ST_OMARK;
				end else begin
					dir_d = dir_q + 1'b1;
				end
			end
			gff_pkg::ST_OLWAIT: st_d = gff_pkg::ST_OLCHK;
			gff_pkg::ST_OLCHK: begin
				if (!wall_rd && rch_rd) link_d = 1'b1;
				if (dir_q == 2'd3) begin
					st_d = gff_pkg::ST_OMARK;
				end else begin
					dir_d = dir_q + 1'b1;
					st_d = gff_pkg::ST_OLREQ;
				end
			end
			gff_pkg::ST_OMARK: begin
				if (link_q && !w_q) begin
					rch_a = o_addr; rch_we = 1'b1; rch_wd = 1'b1;
					q_wd = o_addr;
					if (32'(cnt_q) < CELLS) begin
						q_we = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
					st_d = gff_pkg::ST_POP;
				end else begin
					st_d = gff_pkg::ST_TREQ;
				end
			end
			gff_pkg::ST_TREQ: begin
				rch_a = {RB'(tr_q), CB'(tc_q)};
				st_d = gff_pkg::ST_TWAIT;
			end
			gff_pkg::ST_TWAIT: begin
				tr_res_d = t_in && rch_rd;
				if (t_in && rch_rd && ans_q == -17'sd1) begin
					if (gff_pkg::op_t'(op_q) == gff_pkg::OP_FLOOD) ans_d = '0;
					else if (gff_pkg::op_t'(op_q) == gff_pkg::OP_OPEN)
						ans_d = 17'($unsigned(ev_q));
				end
				st_d = gff_pkg::ST_OUT;
			end
			gff_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) st_d = gff_pkg::ST_IDLE;
			end
			default: st_d = gff_pkg::ST_IDLE;
		endcase
	end

	assign target_reached = tr_res_q;
	assign first_event = ans_q;
endmodule

>>> hdl/gff_checker.sv
// Port-level checker for the flood fill block and its bind.
`timescale 1ns / 1ps
`include "grid_flood_fill_reachability_assert.svh"
module gff_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        target_reached,
	input logic signed [16:0] first_event
);
	// A word is never taken while a result still waits.
	`GFF_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, in_stall, "input taken while output pending")
	// A word just taken cannot have its result ready in the next cycle.
	`GFF_ASSERT_NEXT(a_accept_gap, clk, arst_n, in_valid && !in_stall, !out_valid, "result too early")
	// After a taken result the block is ready again.
	`GFF_ASSERT_NEXT(a_resume, clk, arst_n, out_valid && !out_stall, !out_valid, "result repeated")
	// A waiting result holds its value.
	`GFF_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(first_event) && $stable(target_reached), "result changed while stalled")
endmodule

bind grid_flood_fill_reachability gff_checker u_gff_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.target_reached(target_reached), .first_event(first_event));

>>> tb/sv/tb_grid_flood_fill_reachability.sv
// Self-checking testbench for the grid flood fill reachability block.
`timescale 1ns / 1ps
module tb_grid_flood_fill_reachability;
	import gff_pkg::*;

	// One input word as the driver offers it.
	typedef struct {
		op_t        op;
		logic [5:0] col;
		logic [5:0] row;
		logic       wall;
	} cell_word_t;

	// One result word as the block should report it.
	typedef struct {
		logic               reached;
		logic signed [16:0] first_ev;
	} reach_word_t;

	localparam int GridCells  = MaxCols * MaxRows;
	localparam int EventMax   = (1 << EventBits) - 1;
	localparam int CycleLimit = 3000000;
	localparam int HoldCycles = 400;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [5:0]        col;
	logic [5:0]        row;
	logic              is_wall;
	logic              out_valid;
	logic              out_stall;
	logic              target_reached;
	logic signed [16:0] first_event;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [6:0]        cfg_data;

	grid_flood_fill_reachability dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .col(col), .row(row), .is_wall(is_wall),
		.out_valid(out_valid), .out_stall(out_stall),
		.target_reached(target_reached), .first_event(first_event),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Words waiting to be offered, and results still owed by the block.
	cell_word_t  pending_words[$];
	reach_word_t expected_words[$];
	cell_word_t  offered;

	// Shadow copy of the block's maps, registers and counters.
	bit         wall_grid[GridCells];
	bit         reach_grid[GridCells];
	int         fill_q[$];
	logic [6:0] sh_width, sh_height;
	logic [5:0] sh_tcol, sh_trow;
	int         event_ctr;
	int         first_hit;

	int  send_idle_pct, recv_idle_pct;
	int  hold_req, hold_done, hold_left;
	int  cycles;
	bit  failed;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int used_cols();
		if (sh_width == 0) return 1;
		return (sh_width > MaxCols) ? MaxCols : sh_width;
	endfunction

	function automatic int used_rows();
		if (sh_height == 0) return 1;
		return (sh_height > MaxRows) ? MaxRows : sh_height;
	endfunction

	function automatic bit on_grid(int c, int r);
		return c >= 0 && r >= 0 && c < used_cols() && r < used_rows();
	endfunction

	function automatic bit target_hit();
		if (!on_grid(sh_tcol, sh_trow)) return 0;
		return reach_grid[sh_trow * MaxCols + sh_tcol];
	endfunction

	// Breadth-first spread from whatever cells sit in the fill queue.
	// Cells are marked as they are queued, so each one enters only once.
	function automatic void spread_fill();
		int cur, c, r, nc, nr, n;
		while (fill_q.size() > 0) begin
			cur = fill_q.pop_front();
			c = cur % MaxCols;
			r = cur / MaxCols;
			for (int d = 0; d < 4; d++) begin
				nc = c + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
				nr = r + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
				if (on_grid(nc, nr)) begin
					n = nr * MaxCols + nc;
					if (!wall_grid[n] && !reach_grid[n]) begin
						reach_grid[n] = 1;
						fill_q.push_back(n);
					end
				end
			end
		end
	endfunction

	// Applies one accepted word to the shadow state and queues its result.
	function automatic void predict_reach(cell_word_t w);
		reach_word_t res;
		int pos, nc, nr, n;
		bit link;
		case (w.op)
			OP_LOAD: begin
				wall_grid[w.row * MaxCols + w.col] = w.wall;
			end
			OP_FLOOD: begin
				for (int i = 0; i < GridCells; i++) reach_grid[i] = 0;
				fill_q.delete();
				event_ctr = 0;
				first_hit = -1;
				// The origin counts as reached even when it is a wall.
				reach_grid[0] = 1;
				fill_q.push_back(0);
				spread_fill();
				if (target_hit()) first_hit = 0;
			end
			OP_OPEN: begin
				if (event_ctr < EventMax) event_ctr++;
				if (first_hit != 0 && on_grid(w.col, w.row)) begin
					pos = w.row * MaxCols + w.col;
					if (wall_grid[pos]) begin
						wall_grid[pos] = 0;
						link = 0;
						for (int d = 0; d < 4; d++) begin
							nc = w.col + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
							nr = w.row + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
							if (on_grid(nc, nr)) begin
								n = nr * MaxCols + nc;
								if (!wall_grid[n] && reach_grid[n]) link = 1;
							end
						end
						if (link && !reach_grid[pos]) begin
							reach_grid[pos] = 1;
							fill_q.push_back(pos);
							spread_fill();
						end
						if (first_hit == -1 && target_hit()) first_hit = event_ctr;
					end
				end
			end
			default: ;
		endcase
		res.reached  = target_hit();
		res.first_ev = 17'(first_hit);
		expected_words.push_back(res);
	endfunction

	// Driver: the word on the bus is retired when taken, and a fresh one
	// may be put up in the same cycle. The valid is written once per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= OP_NONE;
			col       <= '0;
			row       <= '0;
			is_wall   <= 1'b0;
		end else begin
			if (in_valid && !in_stall) predict_reach(offered);
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_words.pop_front();
					in_valid  <= 1'b1;
					operation <= offered.op;
					col       <= offered.col;
					row       <= offered.row;
					is_wall   <= offered.wall;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each taken result against the oldest expectation, and
	// drives the stall, including a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		reach_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word: target_reached %0d first_event %0d",
						target_reached, first_event);
					failed = 1;
				end else begin
					want = expected_words.pop_front();
					if (target_reached !== want.reached) begin
						$error("target_reached: expected %0d, actual %0d",
							want.reached, target_reached);
						failed = 1;
					end
					if (first_event !== want.first_ev) begin
						$error("first_event: expected %0d, actual %0d",
							want.first_ev, first_event);
						failed = 1;
					end
				end
			end
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog against a hung block.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("tb_grid_flood_fill_reachability: FAIL");
			$finish;
		end
	end

	function automatic cell_word_t mk_word(op_t op, int c, int r, bit w);
		cell_word_t x;
		x.op   = op;
		x.col  = c[5:0];
		x.row  = r[5:0];
		x.wall = w;
		return x;
	endfunction

	// Waits until the block has answered everything and has gone quiet.
	task automatic wait_drained();
		while (pending_words.size() > 0 || expected_words.size() > 0 || in_valid)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Register writes happen only once the block has drained.
	task automatic set_grid(int w, int h, int tc, int tr);
		logic [6:0] vals[4];
		vals[0] = w[6:0];
		vals[1] = h[6:0];
		vals[2] = tc[6:0];
		vals[3] = tr[6:0];
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_width  = vals[0];
		sh_height = vals[1];
		sh_tcol   = vals[2][5:0];
		sh_trow   = vals[3][5:0];
		@(negedge clk);
	endtask

	// Random phase: mostly load-flood-open sequences confined to the grid in
	// use, with some noise words (stray loads and idle operations) mixed in.
	task automatic queue_random_phase(int words);
		int c, r, n, k;
		n = 0;
		while (n < words) begin
			k = $urandom_range(5, 10);
			for (int i = 0; i < k; i++) begin
				c = $urandom_range(used_cols() - 1);
				r = $urandom_range(used_rows() - 1);
				pending_words.push_back(mk_word(OP_LOAD, c, r, $urandom_range(99) < 40));
			end
			pending_words.push_back(mk_word(OP_FLOOD, $urandom_range(63), $urandom_range(63),
				$urandom_range(1)));
			k = $urandom_range(4, 8);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(99) < 80) begin
					c = $urandom_range(used_cols() - 1);
					r = $urandom_range(used_rows() - 1);
				end else begin
					c = $urandom_range(63);
					r = $urandom_range(63);
				end
				pending_words.push_back(mk_word(OP_OPEN, c, r, $urandom_range(1)));
			end
			case ($urandom_range(2))
				0: pending_words.push_back(mk_word(OP_NONE, $urandom_range(63),
					$urandom_range(63), $urandom_range(1)));
				1: pending_words.push_back(mk_word(OP_LOAD, $urandom_range(63),
					$urandom_range(63), $urandom_range(1)));
				default: ;
			endcase
			n = n + 20;
		end
	endtask

	initial begin
		failed        = 0;
		cycles        = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 0;
		hold_done     = 0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_WIDTH;
		cfg_data      = '0;
		sh_width      = 7'd64;
		sh_height     = 7'd64;
		sh_tcol       = '0;
		sh_trow       = '0;
		event_ctr     = 0;
		first_hit     = -1;
		for (int i = 0; i < GridCells; i++) begin
			wall_grid[i]  = 0;
			reach_grid[i] = 0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the full-size grid with the target on the origin.
		// An open before any flood clears the wall but reaches nothing; the
		// flood marks a walled origin, so the target is reached at once.
		pending_words.push_back(mk_word(OP_NONE, 63, 63, 1));
		pending_words.push_back(mk_word(OP_LOAD, 2, 2, 1));
		pending_words.push_back(mk_word(OP_OPEN, 2, 2, 0));
		pending_words.push_back(mk_word(OP_LOAD, 63, 63, 1));
		pending_words.push_back(mk_word(OP_LOAD, 0, 0, 1));
		pending_words.push_back(mk_word(OP_FLOOD, 0, 0, 0));
		pending_words.push_back(mk_word(OP_LOAD, 63, 62, 1));
		pending_words.push_back(mk_word(OP_OPEN, 63, 63, 1));

		// Small grid with a walled column between origin and target. A load
		// outside the grid in use still writes its wall bit.
		set_grid(4, 4, 3, 3);
		for (int r = 0; r < 4; r++) pending_words.push_back(mk_word(OP_LOAD, 1, r, 1));
		pending_words.push_back(mk_word(OP_LOAD, 10, 10, 1));
		pending_words.push_back(mk_word(OP_FLOOD, 5, 5, 1));
		pending_words.push_back(mk_word(OP_OPEN, 0, 1, 0));
		pending_words.push_back(mk_word(OP_OPEN, 20, 20, 0));
		pending_words.push_back(mk_word(OP_OPEN, 1, 2, 0));
		pending_words.push_back(mk_word(OP_OPEN, 1, 0, 0));
		pending_words.push_back(mk_word(OP_LOAD, 2, 2, 1));
		pending_words.push_back(mk_word(OP_NONE, 0, 0, 0));

		// Random phases, each under its own grid setting and idling pattern.
		set_grid(8, 8, 7, 7);
		queue_random_phase(28);

		set_grid(0, 5, 0, 4);
		send_idle_pct = 57;
		queue_random_phase(20);

		set_grid(127, 2, 63, 1);
		send_idle_pct = 0;
		recv_idle_pct = 57;
		queue_random_phase(28);
		// Hold the result side off for a long stretch while words keep coming.
		hold_req++;

		set_grid(12, 10, 40, 3);
		send_idle_pct = 29;
		recv_idle_pct = 29;
		queue_random_phase(20);

		set_grid(3, 127, 2, 63);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_phase(20);

		wait_drained();
		repeat (200) @(negedge clk);
		if (!failed && expected_words.size() == 0) begin
			$display("tb_grid_flood_fill_reachability: PASS");
		end else begin
			$display("tb_grid_flood_fill_reachability: FAIL");
		end
		$finish;
	end
endmodule
